@@ rtl/mfra_pkg.sv @@
// Shared types, register indexes and reset constants of the rate adjuster.
package mfra_pkg;

  // Default table depth
  localparam int SLOTS_DEF = 16;

  // Field widths
  localparam int INTV_W  = 10;
  localparam int STALE_W = 16;
  localparam int THR_W   = 8;
  localparam int SLOT_W  = 4;
  localparam int REC_W   = 2;
  localparam int TIME_W  = 32;
  localparam int CNT_OUT_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_INTERVAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 3'd4;

  // Reset values
  localparam logic [INTV_W-1:0]  BASE_RST   = 10'd33;
  localparam logic [INTV_W-1:0]  MAX_RST    = 10'd500;
  localparam logic [INTV_W-1:0]  MIN_RST    = 10'd10;
  localparam logic [STALE_W-1:0] STALE_RST  = 16'd10999;
  localparam logic [THR_W-1:0]   THR_RST    = 8'd5;
  localparam logic [INTV_W-1:0]  INTV_RST   = 10'd33;

  // Item opcodes
  localparam logic OP_FEEDBACK   = 1'b0;
  localparam logic OP_DISCONNECT = 1'b1;

  // Recommendation codes
  localparam logic [REC_W-1:0] REC_NORMAL = 2'd0;
  localparam logic [REC_W-1:0] REC_SLOW   = 2'd1;
  localparam logic [REC_W-1:0] REC_READY  = 2'd2;
  localparam logic [REC_W-1:0] REC_SPARE  = 2'd3;  // unassigned, counted as normal

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // input transfer: write/clear slot, clear counters
    logic walk;      // table walk cycle
    logic decide;    // pick direction, multiply by factor
    logic scale;     // divide by five
    logic apply;     // clamp, threshold, update interval
    logic load_out;  // load result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic walk_done;
  } status_t;

endpackage

@@ rtl/majority_feedback_rate_adjuster_core.sv @@
// Top level of the majority feedback rate adjuster.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | op, slot, recommendation, now_ms
//  out      | out_valid / out_ready | interval, changed, active/slow/normal/ready_count
//  cfg      | cfg_we                | cfg_index, cfg_data
//
// A feedback item raises out_valid after the walk reads one table entry per
// cycle on the single read port and evaluates the last read, and three
// arithmetic steps and a result load follow. in_ready returns with out_valid,
// so a new item is taken only once the previous one is in the output register.
// A disconnect skips the walk and arithmetic and goes straight to the result
// load. A new input is taken while the previous result waits in the output
// register; an item stalls in its last step only while that is full.
// Synchronous reset clears all valid bits, loads register defaults and 33 ms.
module majority_feedback_rate_adjuster_core #(
  parameter int SLOTS = mfra_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [mfra_pkg::SLOT_W-1:0]         slot,
  input  logic [mfra_pkg::REC_W-1:0]          recommendation,
  input  logic [mfra_pkg::TIME_W-1:0]         now_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mfra_pkg::INTV_W-1:0]         interval,
  output logic                                changed,
  output logic [mfra_pkg::CNT_OUT_W-1:0]      active_count,
  output logic [mfra_pkg::CNT_OUT_W-1:0]      slow_count,
  output logic [mfra_pkg::CNT_OUT_W-1:0]      normal_count,
  output logic [mfra_pkg::CNT_OUT_W-1:0]      ready_count,
  input  logic                                cfg_we,
  input  logic [mfra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mfra_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mfra_pkg::cmd_t    cmd;
  mfra_pkg::status_t status;

  mfra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  mfra_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .op             (op),
    .slot           (slot),
    .recommendation (recommendation),
    .now_ms         (now_ms),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .interval       (interval),
    .changed        (changed),
    .active_count   (active_count),
    .slow_count     (slow_count),
    .normal_count   (normal_count),
    .ready_count    (ready_count)
  );

endmodule

@@ rtl/mfra_ctrl.sv @@
// Controller state machine of the rate adjuster.
module mfra_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  output logic               out_valid,
  input  logic               out_ready,
  output mfra_pkg::cmd_t     cmd,
  input  mfra_pkg::status_t  status
);

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_DECIDE, S_SCALE, S_APPLY, S_FINISH
  } state_t;

  state_t state;
  logic   in_xfer;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // Commands decoded from state and the handshakes
  always_comb begin
    cmd          = '0;
    cmd.start    = in_xfer;
    cmd.walk     = (state == S_WALK);
    cmd.decide   = (state == S_DECIDE);
    cmd.scale    = (state == S_SCALE);
    cmd.apply    = (state == S_APPLY);
    cmd.load_out = (state == S_FINISH) && (!out_valid || out_ready);
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= (op == mfra_pkg::OP_DISCONNECT) ? S_FINISH : S_WALK;
          end
        end
        S_WALK: begin
          if (status.walk_done) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: state <= S_SCALE;
        S_SCALE:  state <= S_APPLY;
        S_APPLY:  state <= S_FINISH;
        S_FINISH: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/mfra_datapath.sv @@
// Datapath: config registers, feedback table, counters, interval arithmetic.
module mfra_datapath #(
  parameter int SLOTS = mfra_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mfra_pkg::cmd_t                      cmd,
  output mfra_pkg::status_t                   status,
  input  logic                                op,
  input  logic [mfra_pkg::SLOT_W-1:0]         slot,
  input  logic [mfra_pkg::REC_W-1:0]          recommendation,
  input  logic [mfra_pkg::TIME_W-1:0]         now_ms,
  input  logic                                cfg_we,
  input  logic [mfra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mfra_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [mfra_pkg::INTV_W-1:0]         interval,
  output logic                                changed,
  output logic [mfra_pkg::CNT_OUT_W-1:0]      active_count,
  output logic [mfra_pkg::CNT_OUT_W-1:0]      slow_count,
  output logic [mfra_pkg::CNT_OUT_W-1:0]      normal_count,
  output logic [mfra_pkg::CNT_OUT_W-1:0]      ready_count
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ENT_W = mfra_pkg::REC_W + mfra_pkg::TIME_W;
  localparam int PROD_W = 15;   // 1023 * 21 fits
  localparam int PRE_W  = 13;   // dividend into the divide-by-five
  localparam int Q_W    = 11;

  typedef enum logic [2:0] {
    M_HOLD, M_SLOW, M_READY, M_DOWN, M_UP
  } mode_t;

  // Floor divide by five via reciprocal, exact for x below 16384
  function automatic logic [Q_W-1:0] div5(input logic [PRE_W-1:0] x);
    logic [2*PRE_W-1:0] p;
    p = x * 13'd6554;
    return p[2*PRE_W-1:15];
  endfunction

  function automatic logic [mfra_pkg::CNT_OUT_W-1:0] sat5(input logic [CNT_W-1:0] c);
    return (32'(c) > 31) ? 5'd31 : 5'(c);
  endfunction

  // Configuration registers
  logic [mfra_pkg::INTV_W-1:0]  base_interval;
  logic [mfra_pkg::INTV_W-1:0]  max_interval;
  logic [mfra_pkg::INTV_W-1:0]  min_interval;
  logic [mfra_pkg::STALE_W-1:0] stale_limit_ms;
  logic [mfra_pkg::THR_W-1:0]   change_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_interval    <= mfra_pkg::BASE_RST;
      max_interval     <= mfra_pkg::MAX_RST;
      min_interval     <= mfra_pkg::MIN_RST;
      stale_limit_ms   <= mfra_pkg::STALE_RST;
      change_threshold <= mfra_pkg::THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mfra_pkg::REG_BASE_INTERVAL:    base_interval    <= cfg_data[mfra_pkg::INTV_W-1:0];
        mfra_pkg::REG_MAX_INTERVAL:     max_interval     <= cfg_data[mfra_pkg::INTV_W-1:0];
        mfra_pkg::REG_MIN_INTERVAL:     min_interval     <= cfg_data[mfra_pkg::INTV_W-1:0];
        mfra_pkg::REG_STALE_LIMIT:      stale_limit_ms   <= cfg_data[mfra_pkg::STALE_W-1:0];
        mfra_pkg::REG_CHANGE_THRESHOLD: change_threshold <= cfg_data[mfra_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Feedback table: valid bits in flops, recommendation and stamp in memory
  logic [SLOTS-1:0]          valid;
  logic [ENT_W-1:0]          mem [SLOTS];
  logic [ENT_W-1:0]          rd_data;
  logic                      slot_ok;
  logic [IDX_W-1:0]          widx;
  logic [mfra_pkg::TIME_W-1:0] now_r;

  // Walk state
  logic [CNT_W-1:0]          wcnt;
  logic                      issue;
  logic                      eval_pend;
  logic [IDX_W-1:0]          eidx;
  logic [mfra_pkg::TIME_W-1:0] elapsed;
  logic                      stale;
  logic [mfra_pkg::REC_W-1:0] ent_rec;

  assign slot_ok = (32'(slot) < SLOTS);
  assign widx    = IDX_W'(slot);
  assign issue   = cmd.walk && (32'(wcnt) < SLOTS);
  assign status.walk_done = (32'(wcnt) == SLOTS);
  assign ent_rec = rd_data[ENT_W-1:mfra_pkg::TIME_W];
  assign elapsed = now_r - rd_data[mfra_pkg::TIME_W-1:0];
  assign stale   = (elapsed > {16'd0, stale_limit_ms});

  // Table memory port
  always_ff @(posedge clk) begin
    if (cmd.start && (op == mfra_pkg::OP_FEEDBACK) && slot_ok) begin
      mem[widx] <= {recommendation, now_ms};
    end
    if (issue) begin
      rd_data <= mem[wcnt[IDX_W-1:0]];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.start && slot_ok) begin
      valid[widx] <= (op == mfra_pkg::OP_FEEDBACK);
    end else if (eval_pend && valid[eidx] && stale) begin
      valid[eidx] <= 1'b0;
    end
  end

  // Walk counter and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt      <= '0;
      eval_pend <= 1'b0;
    end else begin
      if (cmd.start) begin
        wcnt <= '0;
      end else if (issue) begin
        wcnt <= wcnt + 1'b1;
      end
      eval_pend <= issue;
    end
    if (issue) begin
      eidx <= wcnt[IDX_W-1:0];
    end
    if (cmd.start) begin
      now_r <= now_ms;
    end
  end

  // Recommendation counters
  logic [CNT_W-1:0] active_c, slow_c, normal_c, ready_c;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      active_c <= '0;
      slow_c   <= '0;
      normal_c <= '0;
      ready_c  <= '0;
    end else if (eval_pend && valid[eidx] && !stale) begin
      active_c <= active_c + 1'b1;
      if (ent_rec == mfra_pkg::REC_SLOW) begin
        slow_c <= slow_c + 1'b1;
      end else if (ent_rec == mfra_pkg::REC_READY) begin
        ready_c <= ready_c + 1'b1;
      end else begin
        normal_c <= normal_c + 1'b1;
      end
    end
  end

  // Direction decision and factor
  mode_t                       mode, mode_r;
  logic [4:0]                  factor;
  logic [PROD_W-1:0]           prod;
  logic [PRE_W-1:0]            pre;
  logic [Q_W-1:0]              quot;
  logic [Q_W-1:0]              nxt;
  logic [Q_W-1:0]              cur_x;
  logic [Q_W-1:0]              diff;
  logic [mfra_pkg::INTV_W-1:0] cur;
  logic                        chg;

  assign cur_x = {1'b0, cur};

  always_comb begin
    if (active_c == '0) begin
      mode = M_HOLD;
    end else if (slow_c > (active_c >> 1)) begin
      mode = M_SLOW;
    end else if (ready_c > (active_c >> 1)) begin
      mode = M_READY;
    end else if (cur > base_interval) begin
      mode = M_DOWN;
    end else if (cur < base_interval) begin
      mode = M_UP;
    end else begin
      mode = M_HOLD;
    end
    case (mode)
      M_SLOW:  factor = 5'd6;
      M_READY: factor = 5'd17;
      M_DOWN:  factor = 5'd19;
      M_UP:    factor = 5'd21;
      default: factor = 5'd1;
    endcase
  end

  // Slow path divides by 5, the others by 20 (shift by two then by 5)
  assign pre = (mode_r == M_SLOW) ? prod[PRE_W-1:0] : PRE_W'(prod >> 2);

  // Clamp per direction
  always_comb begin
    case (mode_r)
      M_SLOW:  nxt = (quot > {1'b0, max_interval})  ? {1'b0, max_interval}  : quot;
      M_READY: nxt = (quot < {1'b0, min_interval})  ? {1'b0, min_interval}  : quot;
      M_DOWN:  nxt = (quot < {1'b0, base_interval}) ? {1'b0, base_interval} : quot;
      M_UP:    nxt = (quot > {1'b0, base_interval}) ? {1'b0, base_interval} : quot;
      default: nxt = cur_x;
    endcase
    diff = (nxt > cur_x) ? (nxt - cur_x) : (cur_x - nxt);
  end

  // Arithmetic steps and current interval
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      mode_r <= mode;
      prod   <= cur * factor;
    end
    if (cmd.scale) begin
      quot <= div5(pre);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= mfra_pkg::INTV_RST;
      chg <= 1'b0;
    end else if (cmd.start) begin
      chg <= 1'b0;
    end else if (cmd.apply && (diff > {3'd0, change_threshold})) begin
      cur <= nxt[mfra_pkg::INTV_W-1:0];
      chg <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      interval     <= cur;
      changed      <= chg;
      active_count <= sat5(active_c);
      slow_count   <= sat5(slow_c);
      normal_count <= sat5(normal_c);
      ready_count  <= sat5(ready_c);
    end
  end

endmodule

@@ rtl/mfra_checker.sv @@
// Port-level checks of the rate adjuster, bound to the top level.
module mfra_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mfra_pkg::INTV_W-1:0]    interval,
  input logic                           changed,
  input logic [mfra_pkg::CNT_OUT_W-1:0] active_count,
  input logic [mfra_pkg::CNT_OUT_W-1:0] slow_count,
  input logic [mfra_pkg::CNT_OUT_W-1:0] normal_count,
  input logic [mfra_pkg::CNT_OUT_W-1:0] ready_count
);

  logic                        seen;
  logic [mfra_pkg::INTV_W-1:0] last_interval;
  logic [6:0]                  rec_sum;

  assign rec_sum = 7'(slow_count) + 7'(normal_count) + 7'(ready_count);

  // Track the interval of the last result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen          <= 1'b1;
      last_interval <= interval;
    end
  end

  // The block is busy right after taking an item
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high in cycle after input transfer");

  // A change requires fresh entries
  a_change_needs_active: assert property (@(posedge clk) disable iff (rst)
    (out_valid && changed) |-> (active_count != 5'd0))
    else $error("changed set with no active entries");

  // Per-recommendation counts add up to the active count when unsaturated
  a_counts_sum: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (active_count != 5'd31)) |-> (rec_sum == 7'(active_count)))
    else $error("recommendation counts do not sum to active count");

  // Without a change the interval repeats the previous result
  a_interval_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !changed && seen) |-> (interval == last_interval))
    else $error("interval moved without changed flag");

endmodule

bind majority_feedback_rate_adjuster_core mfra_checker u_mfra_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .interval     (interval),
  .changed      (changed),
  .active_count (active_count),
  .slow_count   (slow_count),
  .normal_count (normal_count),
  .ready_count  (ready_count)
);

@@ dv/rate_checker.sv @@
// Checker for the rate adjuster: predicts each result from the input transfers and compares.
module rate_checker
  import mfra_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  op,
  input  logic [SLOT_W-1:0]     slot,
  input  logic [REC_W-1:0]      recommendation,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [INTV_W-1:0]     interval,
  input  logic                  changed,
  input  logic [CNT_OUT_W-1:0]  active_count,
  input  logic [CNT_OUT_W-1:0]  slow_count,
  input  logic [CNT_OUT_W-1:0]  normal_count,
  input  logic [CNT_OUT_W-1:0]  ready_count,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic [INTV_W-1:0]    interval;
    logic                 changed;
    logic [CNT_OUT_W-1:0] active;
    logic [CNT_OUT_W-1:0] slow;
    logic [CNT_OUT_W-1:0] normal;
    logic [CNT_OUT_W-1:0] ready;
  } rate_result_t;

  // Shadow copy of the subscriber table and the interval
  logic              tab_valid [SLOTS];
  logic [REC_W-1:0]  tab_rec   [SLOTS];
  logic [TIME_W-1:0] tab_stamp [SLOTS];
  logic [INTV_W-1:0] cur_intv;

  // Shadow registers
  logic [INTV_W-1:0]  base_r;
  logic [INTV_W-1:0]  max_r;
  logic [INTV_W-1:0]  min_r;
  logic [STALE_W-1:0] stale_r;
  logic [THR_W-1:0]   thr_r;

  rate_result_t pending_results [$];
  int           err_count;

  function automatic logic [CNT_OUT_W-1:0] sat_count(input int unsigned n);
    return (n > 31) ? 5'd31 : 5'(n);
  endfunction

  // Apply one item to the shadow state and return the result it must produce
  function automatic rate_result_t predict_result(input logic o,
                                                  input logic [SLOT_W-1:0] s,
                                                  input logic [REC_W-1:0] r,
                                                  input logic [TIME_W-1:0] t);
    rate_result_t      res;
    logic [TIME_W-1:0] age;
    int unsigned       act, slw, nrm, rdy, cur, nxt, dif;
    logic              upd;
    act = 0;
    slw = 0;
    nrm = 0;
    rdy = 0;
    cur = cur_intv;
    nxt = cur;
    upd = 1'b0;
    if (o == OP_DISCONNECT) begin
      if (s < SLOTS) tab_valid[s] = 1'b0;
    end else begin
      if (s < SLOTS) begin
        tab_valid[s] = 1'b1;
        tab_rec[s]   = r;
        tab_stamp[s] = t;
      end
      // walk: drop stale entries, count the fresh ones
      for (int i = 0; i < SLOTS; i++) begin
        if (tab_valid[i]) begin
          age = t - tab_stamp[i];
          if (age > stale_r) begin
            tab_valid[i] = 1'b0;
          end else begin
            act++;
            if (tab_rec[i] == REC_SLOW) slw++;
            else if (tab_rec[i] == REC_READY) rdy++;
            else nrm++;
          end
        end
      end
      // majority decision, then threshold
      if (act > 0) begin
        if (slw > act / 2) begin
          nxt = cur * 6 / 5;
          if (nxt > max_r) nxt = max_r;
        end else if (rdy > act / 2) begin
          nxt = cur * 17 / 20;
          if (nxt < min_r) nxt = min_r;
        end else if (cur > base_r) begin
          nxt = cur * 19 / 20;
          if (nxt < base_r) nxt = base_r;
        end else if (cur < base_r) begin
          nxt = cur * 21 / 20;
          if (nxt > base_r) nxt = base_r;
        end
        dif = (nxt > cur) ? nxt - cur : cur - nxt;
        if (dif > thr_r) begin
          cur_intv = nxt[INTV_W-1:0];
          upd = 1'b1;
        end
      end
    end
    res.interval = cur_intv;
    res.changed  = upd;
    res.active   = sat_count(act);
    res.slow     = sat_count(slw);
    res.normal   = sat_count(nrm);
    res.ready    = sat_count(rdy);
    return res;
  endfunction

  // Track config, predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    rate_result_t got;
    rate_result_t want;
    rate_result_t pred;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        tab_valid[i] = 1'b0;
        tab_rec[i]   = '0;
        tab_stamp[i] = '0;
      end
      cur_intv = INTV_RST;
      base_r   = BASE_RST;
      max_r    = MAX_RST;
      min_r    = MIN_RST;
      stale_r  = STALE_RST;
      thr_r    = THR_RST;
      pending_results.delete();
      err_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_INTERVAL:    base_r  = cfg_data[INTV_W-1:0];
          REG_MAX_INTERVAL:     max_r   = cfg_data[INTV_W-1:0];
          REG_MIN_INTERVAL:     min_r   = cfg_data[INTV_W-1:0];
          REG_STALE_LIMIT:      stale_r = cfg_data[STALE_W-1:0];
          REG_CHANGE_THRESHOLD: thr_r   = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pred = predict_result(op, slot, recommendation, now_ms);
        pending_results = {pending_results, pred};
      end
      if (out_valid && out_ready) begin
        got = '{interval, changed, active_count, slow_count, normal_count, ready_count};
        if (pending_results.size() == 0) begin
          if (err_count < 10)
            $display("unexpected result: interval %0d changed %0d a%0d s%0d n%0d r%0d",
                     got.interval, got.changed, got.active, got.slow, got.normal, got.ready);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.interval != want.interval || got.changed != want.changed ||
              got.active != want.active || got.slow != want.slow ||
              got.normal != want.normal || got.ready != want.ready) begin
            if (err_count < 10) begin
              $display("result mismatch: expected interval %0d changed %0d a%0d s%0d n%0d r%0d",
                       want.interval, want.changed, want.active, want.slow, want.normal,
                       want.ready);
              $display("  got interval %0d changed %0d a%0d s%0d n%0d r%0d",
                       got.interval, got.changed, got.active, got.slow, got.normal,
                       got.ready);
            end
            err_count++;
          end
        end
      end
    end
    mismatches  <= err_count;
    outstanding <= pending_results.size();
  end

endmodule

@@ dv/tb.sv @@
// Testbench top for the rate adjuster: stimulus, register phases and the final verdict.
module tb;
  import mfra_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 106;

  logic                  clk;
  logic                  rst            = 1'b1;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic                  op             = OP_FEEDBACK;
  logic [SLOT_W-1:0]     slot           = '0;
  logic [REC_W-1:0]      recommendation = '0;
  logic [TIME_W-1:0]     now_ms         = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [INTV_W-1:0]     interval;
  logic                  changed;
  logic [CNT_OUT_W-1:0]  active_count;
  logic [CNT_OUT_W-1:0]  slow_count;
  logic [CNT_OUT_W-1:0]  normal_count;
  logic [CNT_OUT_W-1:0]  ready_count;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  int mismatches;
  int outstanding;

  bit quiet    = 1'b0;  // no idling on either side
  bit hold_req = 1'b0;  // receiver requests a hold-off of out_ready

  majority_feedback_rate_adjuster_core DUT (.*);

  rate_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: random back-pressure, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 27);
      end
    end
  end

  // Offer one item and wait for its transfer
  task automatic send_item(input logic o, input logic [SLOT_W-1:0] s,
                           input logic [REC_W-1:0] r, input logic [TIME_W-1:0] t);
    if (!quiet) begin
      while ($urandom_range(99) < 27) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    op             <= o;
    slot           <= s;
    recommendation <= r;
    now_ms         <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the sender until every predicted result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write all registers, then the unused indexes; block must be idle
  task automatic program_regs(input logic [CFG_DATA_W-1:0] b, input logic [CFG_DATA_W-1:0] mx,
                              input logic [CFG_DATA_W-1:0] mn, input logic [CFG_DATA_W-1:0] st,
                              input logic [CFG_DATA_W-1:0] th);
    logic [CFG_DATA_W-1:0] vals [5];
    vals = '{b, mx, mn, st, th};
    for (int k = 0; k < 8; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data  <= (k <= REG_CHANGE_THRESHOLD) ? vals[k] : CFG_DATA_W'($urandom());
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stimulus and verdict
  initial begin
    logic [TIME_W-1:0]  t;
    logic [STALE_W-1:0] stale;
    logic [REC_W-1:0]   mood;
    logic [REC_W-1:0]   r;
    int unsigned        b, mx, mn;
    int unsigned        pick;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings
    t = 32'h0000_1000;
    send_item(OP_FEEDBACK, 4'd0, REC_NORMAL, t);    // lone normal
    send_item(OP_FEEDBACK, 4'd1, REC_SLOW, t + 1);  // no strict majority
    send_item(OP_FEEDBACK, 4'd2, REC_SLOW, t + 2);  // slow majority, raise
    send_item(OP_FEEDBACK, 4'd3, REC_SLOW, t + 3);
    send_item(OP_FEEDBACK, 4'd15, REC_READY, t + 4);
    send_item(OP_FEEDBACK, 4'd4, REC_SPARE, t + 5);  // unknown code counts as normal
    send_item(OP_DISCONNECT, 4'd1, REC_SPARE, 32'hFFFF_FFFF);
    for (int k = 5; k < 10; k++)
      send_item(OP_FEEDBACK, SLOT_W'(k), REC_READY, t + 6);  // ready majority, lower
    // age exactly at the stale limit is kept, one past it is dropped
    send_item(OP_FEEDBACK, 4'd10, REC_NORMAL, t + 4 + 32'(STALE_RST));
    send_item(OP_FEEDBACK, 4'd11, REC_READY, t + 5 + 32'(STALE_RST));
    send_item(OP_FEEDBACK, 4'd12, REC_SLOW, 32'h0000_0000);
    // elapsed time across the wrap
    send_item(OP_FEEDBACK, 4'd7, REC_SLOW, 32'hFFFF_FFF0);
    send_item(OP_FEEDBACK, 4'd8, REC_SLOW, 32'h0000_0005);
    send_item(OP_DISCONNECT, 4'd15, REC_NORMAL, 32'h0000_0000);
    send_item(OP_DISCONNECT, 4'd0, REC_READY, 32'h1234_5678);
    send_item(OP_FEEDBACK, 4'd10, REC_SPARE, 32'hAAAA_5555);
    send_item(OP_FEEDBACK, 4'd5, REC_READY, 32'h5555_AAAA);
    drain();

    // Random phases, each with its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          program_regs(16'd1, 16'd1000, 16'd1, 16'd0, 16'd0);
          stale = 16'd0;
        end
        1: begin
          program_regs(16'd1000, 16'd1, 16'd1000, 16'hFFFF, 16'd255);
          stale = 16'hFFFF;
        end
        2: begin
          // bits above each register width are dropped
          program_regs(16'hFFFF, 16'hFFFF, 16'h0400, 16'hFFFF, 16'hFF00);
          stale = 16'hFFFF;
        end
        default: begin
          b  = $urandom_range(1, 1000);
          mx = $urandom_range(b, 1000);
          mn = $urandom_range(1, b);
          stale = STALE_W'($urandom_range(200, 20000));
          program_regs(CFG_DATA_W'(b), CFG_DATA_W'(mx), CFG_DATA_W'(mn), stale,
                       CFG_DATA_W'($urandom_range(0, 8)));
        end
      endcase
      quiet = (ph == 3);
      t = $urandom();
      mood = REC_W'($urandom_range(0, 2));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == 20) hold_req = 1'b1;
        if (n == PHASE_ITEMS / 2) drain();
        if ($urandom_range(19) == 0) mood = REC_W'($urandom_range(0, 2));
        r = ($urandom_range(99) < 70) ? mood : REC_W'($urandom_range(0, 3));
        pick = $urandom_range(99);
        if (pick < 12) begin
          send_item(OP_DISCONNECT, SLOT_W'($urandom()), REC_W'($urandom()), $urandom());
        end else if (pick < 17) begin
          send_item(OP_FEEDBACK, SLOT_W'($urandom()), r, $urandom());  // noise
        end else if (pick < 22) begin
          // jump close to the stale limit
          t = t + $urandom_range(stale, 32'(stale) + 2);
          send_item(OP_FEEDBACK, SLOT_W'($urandom()), r, t);
        end else begin
          if ($urandom_range(99) >= 20) t = t + $urandom_range(0, stale / 6 + 2);
          send_item(OP_FEEDBACK, SLOT_W'($urandom()), r, t);
        end
      end
      drain();
      quiet = 1'b0;
    end

    repeat (30) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mfra_pkg.sv
rtl/mfra_ctrl.sv
rtl/mfra_datapath.sv
rtl/majority_feedback_rate_adjuster_core.sv
rtl/mfra_checker.sv
dv/rate_checker.sv
dv/tb.sv
